FILE: rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_CLK_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_CLK_NORST(label, clk, prop, msg)
`endif
`endif

FILE: rtl/rmrq_pkg.sv
// ----------------------------------------------------------------------------
// rmrq_pkg
// types and codes shared by the rate monotonic ready queue
// ----------------------------------------------------------------------------
package rmrq_pkg;
   localparam int CAPACITY_DEF = 16;

   localparam logic [2:0] FN_ASSIGN = 3'd0;
   localparam logic [2:0] FN_UPDATE = 3'd1;
   localparam logic [2:0] FN_ADD    = 3'd2;
   localparam logic [2:0] FN_REMOVE = 3'd3;
   localparam logic [2:0] FN_PEEK   = 3'd4;
   localparam logic [2:0] FN_SELECT = 3'd5;
   localparam logic [2:0] FN_CLEAR  = 3'd6;
   localparam logic [2:0] FN_RSVD   = 3'd7;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_PARAM     = 3'd1;
   localparam logic [2:0] ST_DUP       = 3'd2;
   localparam logic [2:0] ST_OVERFLOW  = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;

   typedef struct packed {
      logic [2:0]  func;
      logic [15:0] task_id;
      logic [31:0] period;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] task_out;
      logic [4:0]  q_depth;
      logic        ready_res;
   } rsp_type;
endpackage

FILE: rtl/rmrq_engine.sv
// ----------------------------------------------------------------------------
// rmrq_engine
// sequencer that walks the registry and queue one entry per cycle
// ----------------------------------------------------------------------------
module rmrq_engine #(
   parameter int CAPACITY = rmrq_pkg::CAPACITY_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  rmrq_pkg::req_type req,
   output logic              busy,
   output logic              done,
   output rmrq_pkg::rsp_type rsp
);
   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RSCAN = 3'd1;
   localparam logic [2:0] S_QSCAN = 3'd2;
   localparam logic [2:0] S_SHIFT = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]    state_ff;
   rmrq_pkg::req_type cmd_ff;
   logic [CW-1:0] idx_ff;
   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] pos_ff;
   logic [IW-1:0] reg_hit_ff, reg_free_ff;
   logic          reg_hit_v_ff, reg_free_v_ff;
   logic [31:0]   per_ff;
   logic [2:0]    status_ff;
   logic [15:0]   head_ff;

   logic [CAPACITY-1:0] reg_active_ff;
   logic [15:0] reg_task_ff   [CAPACITY];
   logic [31:0] reg_period_ff [CAPACITY];
   logic [15:0] q_task_ff     [CAPACITY];
   logic [31:0] q_period_ff   [CAPACITY];

   logic [IW-1:0] idx;
   logic          shift_up;
   assign idx  = idx_ff[IW-1:0];
   assign busy = (state_ff != S_IDLE);
   assign done = (state_ff == S_DONE);
   assign shift_up = (cmd_ff.func == rmrq_pkg::FN_ADD);
   assign rsp.status    = status_ff;
   assign rsp.task_out  = head_ff;
   assign rsp.q_depth   = 5'(cnt_ff);
   assign rsp.ready_res = (cnt_ff != '0);

   // sequencer and shared compare walk
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         reg_active_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  cmd_ff        <= req;
                  idx_ff        <= '0;
                  reg_hit_v_ff  <= 1'b0;
                  reg_free_v_ff <= 1'b0;
                  head_ff       <= '0;
                  status_ff     <= rmrq_pkg::ST_OK;
                  pos_ff        <= cnt_ff;
                  state_ff      <= S_DONE;
                  case (req.func) inside
                     rmrq_pkg::FN_ASSIGN, rmrq_pkg::FN_UPDATE: begin
                        if (req.task_id == '0 || req.period == '0)
                           status_ff <= rmrq_pkg::ST_PARAM;
                        else state_ff <= S_RSCAN;
                     end
                     rmrq_pkg::FN_ADD: begin
                        if (req.task_id == '0) status_ff <= rmrq_pkg::ST_PARAM;
                        else if (cnt_ff >= CW'(CAPACITY))
                           status_ff <= rmrq_pkg::ST_OVERFLOW;
                        else state_ff <= S_QSCAN;
                     end
                     rmrq_pkg::FN_REMOVE: begin
                        if (req.task_id == '0) status_ff <= rmrq_pkg::ST_PARAM;
                        else state_ff <= S_QSCAN;
                     end
                     rmrq_pkg::FN_PEEK, rmrq_pkg::FN_SELECT: begin
                        if (cnt_ff == '0) status_ff <= rmrq_pkg::ST_NOT_FOUND;
                        else begin
                           head_ff <= q_task_ff[0];
                           if (req.func == rmrq_pkg::FN_SELECT) begin
                              pos_ff   <= '0;
                              state_ff <= S_SHIFT;
                           end
                        end
                     end
                     rmrq_pkg::FN_CLEAR: cnt_ff <= '0;
                     default: status_ff <= rmrq_pkg::ST_PARAM;
                  endcase
               end
            end
            // registry scan: find id and first free slot
            S_RSCAN: begin
               if (reg_active_ff[idx] && reg_task_ff[idx] == cmd_ff.task_id &&
                   !reg_hit_v_ff) begin
                  reg_hit_v_ff <= 1'b1;
                  reg_hit_ff   <= idx;
               end
               if (!reg_active_ff[idx] && !reg_free_v_ff) begin
                  reg_free_v_ff <= 1'b1;
                  reg_free_ff   <= idx;
               end
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == CW'(CAPACITY - 1)) begin
                  state_ff <= S_DONE;
                  if (cmd_ff.func == rmrq_pkg::FN_ADD) begin
                     if (reg_hit_v_ff) begin
                        per_ff   <= reg_period_ff[reg_hit_ff];
                        idx_ff   <= '0;
                        pos_ff   <= cnt_ff;
                        state_ff <= S_SHIFT;
                     end else if (reg_active_ff[idx] &&
                                  reg_task_ff[idx] == cmd_ff.task_id) begin
                        per_ff   <= reg_period_ff[idx];
                        idx_ff   <= '0;
                        pos_ff   <= cnt_ff;
                        state_ff <= S_SHIFT;
                     end else status_ff <= rmrq_pkg::ST_NOT_FOUND;
                  end else begin
                     if (reg_hit_v_ff)
                        reg_period_ff[reg_hit_ff] <= cmd_ff.period;
                     else if (reg_active_ff[idx] &&
                              reg_task_ff[idx] == cmd_ff.task_id)
                        reg_period_ff[idx] <= cmd_ff.period;
                     else if (cmd_ff.func == rmrq_pkg::FN_UPDATE)
                        status_ff <= rmrq_pkg::ST_NOT_FOUND;
                     else if (reg_free_v_ff || !reg_active_ff[idx]) begin
                        reg_active_ff[reg_free_v_ff ? reg_free_ff : idx] <= 1'b1;
                        reg_task_ff[reg_free_v_ff ? reg_free_ff : idx] <=
                           cmd_ff.task_id;
                        reg_period_ff[reg_free_v_ff ? reg_free_ff : idx] <=
                           cmd_ff.period;
                     end else status_ff <= rmrq_pkg::ST_OVERFLOW;
                  end
               end
            end
            // queue scan: find id in queue
            S_QSCAN: begin
               if (idx_ff >= cnt_ff) begin
                  idx_ff <= '0;
                  if (cmd_ff.func == rmrq_pkg::FN_ADD) state_ff <= S_RSCAN;
                  else begin
                     status_ff <= rmrq_pkg::ST_NOT_FOUND;
                     state_ff  <= S_DONE;
                  end
               end else if (q_task_ff[idx] == cmd_ff.task_id) begin
                  if (cmd_ff.func == rmrq_pkg::FN_ADD) begin
                     status_ff <= rmrq_pkg::ST_DUP;
                     state_ff  <= S_DONE;
                  end else begin
                     pos_ff   <= idx_ff;
                     state_ff <= S_SHIFT;
                  end
               end else idx_ff <= idx_ff + 1'b1;
            end
            // shift: add moves up from tail, drop moves down from pos
            S_SHIFT: begin
               if (shift_up) begin
                  // pos_ff walks down from the tail to the insertion point
                  if (pos_ff != '0 && q_period_ff[pos_ff[IW-1:0] - 1'b1] > per_ff)
                  begin
                     q_task_ff[pos_ff[IW-1:0]]   <= q_task_ff[pos_ff[IW-1:0] - 1'b1];
                     q_period_ff[pos_ff[IW-1:0]] <= q_period_ff[pos_ff[IW-1:0] - 1'b1];
                     pos_ff <= pos_ff - 1'b1;
                  end else begin
                     q_task_ff[pos_ff[IW-1:0]]   <= cmd_ff.task_id;
                     q_period_ff[pos_ff[IW-1:0]] <= per_ff;
                     cnt_ff   <= cnt_ff + 1'b1;
                     state_ff <= S_DONE;
                  end
               end else begin
                  if (pos_ff + 1'b1 < cnt_ff) begin
                     q_task_ff[pos_ff[IW-1:0]]   <= q_task_ff[pos_ff[IW-1:0] + 1'b1];
                     q_period_ff[pos_ff[IW-1:0]] <= q_period_ff[pos_ff[IW-1:0] + 1'b1];
                     pos_ff <= pos_ff + 1'b1;
                  end else begin
                     cnt_ff   <= cnt_ff - 1'b1;
                     state_ff <= S_DONE;
                  end
               end
            end
            S_DONE: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

FILE: rtl/rate_monotonic_ready_queue_top.sv
// sequencing: a request may run through the queue scan, the registry scan of all
// CAPACITY slots and the one-entry-per-cycle shift before the response is valid
// throughput: one request at a time; the next is taken the cycle after the
// response is accepted
// reset: synchronous, clears the queue count and registry valid bits
// ----------------------------------------------------------------------------
// rate_monotonic_ready_queue_top
// rate monotonic ready queue with registry and skid-free response register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module rate_monotonic_ready_queue_top #(
   parameter int CAPACITY = rmrq_pkg::CAPACITY_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rmrq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rmrq_pkg::rsp_type rsp_data
);
   localparam logic [4:0] CNT_MAX = 5'(CAPACITY);

   logic busy, done, rsp_valid_ff;
   rmrq_pkg::rsp_type eng_rsp, rsp_ff;

   assign req_ready = !busy && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   rmrq_engine #(.CAPACITY(CAPACITY)) u_engine (
      .clock(clock), .reset(reset), .start(req_valid && req_ready),
      .req(req_data), .busy(busy), .done(done), .rsp(eng_rsp)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (done) begin
         rsp_valid_ff <= 1'b1;
         rsp_ff       <= eng_rsp;
      end else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   `ASSERT_CLK(a_no_accept_busy, clock, reset, busy |-> !req_ready, "accept while busy")
   `ASSERT_CLK(a_done_idle_rsp, clock, reset, done |-> !rsp_valid_ff, "done over pending response")
   `ASSERT_CLK(a_cnt_range, clock, reset, rsp_valid |-> rsp_data.q_depth <= CNT_MAX, "count high")
endmodule
